// ===== src/mlqs_pkg.sv =====
package mlqs_pkg;

   localparam int LEVELS = 4;
   localparam int TW = 16;
   localparam logic [TW-1:0] TMAX = 16'hFFFF;

   localparam logic [1:0] POL_RR = 2'd0;
   localparam logic [1:0] POL_SJF = 2'd1;
   localparam logic [1:0] POL_STCF = 2'd2;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   localparam logic [2:0] CSR_POLICY0 = 3'd0;
   localparam logic [2:0] CSR_QUANTUM0 = 3'd4;

   typedef struct packed {
      logic        action;
      logic [3:0]  slot;
      logic [15:0] burst;
      logic [15:0] arrival;
      logic [1:0]  level;
   } req_type;

   typedef struct packed {
      logic [15:0] time_unit;
      logic        busy_res;
      logic [3:0]  run_slot;
      logic        finished;
      logic [15:0] completion;
      logic [15:0] turnaround;
      logic [15:0] waiting;
      logic [15:0] response;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic do_load;     // write the request's slot
      logic tick_begin;  // check the active slice, drop it if its process is empty
      logic scan_clear;  // restart the scan on a new level
      logic scan_step;   // examine one slot
      logic commit;      // install the chosen slice
      logic run;         // run the current slot and build the beat
      logic idle;        // idle tick, build the beat
   } cmd_type;

   typedef struct packed {
      logic slice_active;
      logic found;
   } sts_type;

endpackage

// ===== src/mlqs_ctrl.sv =====
module mlqs_ctrl #(
   parameter int SLOTS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_action,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  mlqs_pkg::sts_type  sts,
   output mlqs_pkg::cmd_type  cmd,
   output logic [1:0]         scan_level
);
   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_SCAN = 3'd2;
   localparam logic [2:0] ST_DECIDE = 3'd3;
   localparam logic [2:0] ST_RUN = 3'd4;
   localparam logic [2:0] ST_OUT = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [1:0] lvl_ff, lvl_in;
   logic out_ff, out_in;
   logic accept;

   assign req_stall = (state_ff != ST_IDLE) || (out_ff && rsp_stall);
   assign rsp_valid = out_ff;
   assign accept = req_valid && !req_stall;
   assign scan_level = lvl_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      lvl_in = lvl_ff;
      out_in = out_ff && rsp_stall;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_action == mlqs_pkg::ACT_LOAD) begin
                  cmd.do_load = 1'b1;
                  out_in = 1'b1;
               end else begin
                  cmd.tick_begin = 1'b1;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (sts.slice_active) begin
               state_in = ST_RUN;
            end else begin
               cmd.scan_clear = 1'b1;
               lvl_in = 2'd0;
               cnt_in = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(SLOTS - 1)) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (sts.found) begin
               cmd.commit = 1'b1;
               state_in = ST_RUN;
            end else if (lvl_ff == 2'(mlqs_pkg::LEVELS - 1)) begin
               cmd.idle = 1'b1;
               state_in = ST_OUT;
            end else begin
               cmd.scan_clear = 1'b1;
               lvl_in = lvl_ff + 2'd1;
               cnt_in = '0;
               state_in = ST_SCAN;
            end
         end
         ST_RUN: begin
            cmd.run = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!out_ff || !rsp_stall) begin
               out_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         lvl_ff <= '0;
         out_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         lvl_ff <= lvl_in;
         out_ff <= out_in;
      end
   end
endmodule

// ===== src/mlqs_dp.sv =====
module mlqs_dp #(
   parameter int SLOTS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  mlqs_pkg::req_type   req_data,
   input  logic                load_beat,
   input  logic                rsp_stall,
   input  logic                rsp_valid,
   output mlqs_pkg::rsp_type   rsp_data,
   input  logic                csr_write,
   input  logic [2:0]          csr_index,
   input  logic [7:0]          csr_wdata,
   input  mlqs_pkg::cmd_type   cmd,
   input  logic [1:0]          scan_level,
   output mlqs_pkg::sts_type   sts
);
   localparam int SW = $clog2(SLOTS);
   localparam int L = mlqs_pkg::LEVELS;

   logic [15:0] burst_ff [SLOTS];
   logic [15:0] arr_ff [SLOTS];
   logic [1:0]  lvl_ff [SLOTS];
   logic [15:0] rem_ff [SLOTS];
   logic [SLOTS-1:0] started_ff;
   logic [15:0] first_ff [SLOTS];
   logic [1:0]  pol_ff [L];
   logic [7:0]  quant_ff [L];
   logic [SW-1:0] rot_ff [L];
   logic [15:0] now_ff;
   logic [SW-1:0] cur_ff;
   logic [15:0] slice_ff;
   logic [SW-1:0] idx_ff, best_ff;
   logic [15:0] bkey_ff;
   logic found_ff;
   mlqs_pkg::rsp_type beat_ff, beat_in;

   logic [1:0] pol;
   logic [SW-1:0] slot_i;
   logic [SW:0] rr_sum;
   logic rdy, keyless, ismin;
   logic [15:0] key, q, rem_new, now_new, tat, wt;
   logic in_range;

   assign pol = pol_ff[scan_level];
   // Round robin starts at the level's pointer and wraps at the slot count.
   assign rr_sum = {1'b0, idx_ff} + {1'b0, rot_ff[scan_level]};
   assign slot_i = ismin ? idx_ff :
                   (rr_sum >= (SW+1)'(SLOTS)) ? SW'(rr_sum - (SW+1)'(SLOTS)) : SW'(rr_sum);
   assign rdy = rem_ff[slot_i] != 16'd0 && arr_ff[slot_i] <= now_ff &&
                lvl_ff[slot_i] == scan_level;
   assign key = pol == mlqs_pkg::POL_SJF ? burst_ff[slot_i] : rem_ff[slot_i];
   assign keyless = key < bkey_ff;
   assign ismin = pol == mlqs_pkg::POL_SJF || pol == mlqs_pkg::POL_STCF;
   assign q = quant_ff[scan_level] == 8'd0 ? 16'd1 : {8'd0, quant_ff[scan_level]};
   assign rem_new = rem_ff[cur_ff] - 16'd1;
   assign now_new = now_ff == mlqs_pkg::TMAX ? now_ff : now_ff + 16'd1;
   assign tat = now_new >= arr_ff[cur_ff] ? now_new - arr_ff[cur_ff] : 16'd0;
   assign wt = tat >= burst_ff[cur_ff] ? tat - burst_ff[cur_ff] : 16'd0;
   assign in_range = {3'b000, req_data.slot} < 7'(SLOTS);

   assign sts.slice_active = slice_ff != 16'd0;
   assign sts.found = found_ff;

   always_comb begin
      beat_in = beat_ff;
      if (load_beat) beat_in = '0;
      if (cmd.idle) begin
         beat_in = '0;
         beat_in.time_unit = now_ff;
      end
      if (cmd.run) begin
         beat_in = '0;
         beat_in.time_unit = now_ff;
         beat_in.busy_res = 1'b1;
         beat_in.run_slot = 4'(cur_ff);
         if (rem_new == 16'd0) begin
            beat_in.finished = 1'b1;
            beat_in.completion = now_new;
            beat_in.turnaround = tat;
            beat_in.waiting = wt;
            beat_in.response = first_ff[cur_ff];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!(rsp_valid && rsp_stall) || cmd.idle || cmd.run) beat_ff <= beat_in;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            burst_ff[i] <= '0;
            arr_ff[i] <= '0;
            lvl_ff[i] <= '0;
            rem_ff[i] <= '0;
            first_ff[i] <= '0;
         end
         started_ff <= '0;
         for (int l = 0; l < L; l++) rot_ff[l] <= '0;
         pol_ff[0] <= mlqs_pkg::POL_RR;
         pol_ff[1] <= mlqs_pkg::POL_RR;
         pol_ff[2] <= mlqs_pkg::POL_RR;
         pol_ff[3] <= mlqs_pkg::POL_SJF;
         quant_ff[0] <= 8'd1;
         quant_ff[1] <= 8'd3;
         quant_ff[2] <= 8'd4;
         quant_ff[3] <= 8'd20;
         now_ff <= '0;
         cur_ff <= '0;
         slice_ff <= '0;
         idx_ff <= '0;
         best_ff <= '0;
         bkey_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            if (csr_index < mlqs_pkg::CSR_QUANTUM0)
               pol_ff[2'(csr_index - mlqs_pkg::CSR_POLICY0)] <= csr_wdata[1:0];
            else
               quant_ff[2'(csr_index - mlqs_pkg::CSR_QUANTUM0)] <= csr_wdata;
         end
         if (cmd.do_load && in_range) begin
            burst_ff[SW'(req_data.slot)] <= req_data.burst;
            arr_ff[SW'(req_data.slot)] <= req_data.arrival;
            lvl_ff[SW'(req_data.slot)] <= req_data.level;
            rem_ff[SW'(req_data.slot)] <= req_data.burst;
            started_ff[SW'(req_data.slot)] <= 1'b0;
            first_ff[SW'(req_data.slot)] <= '0;
            if (SW'(req_data.slot) == cur_ff) slice_ff <= '0;
         end
         // A slice whose process was emptied by a reload is dropped.
         if (cmd.tick_begin && rem_ff[cur_ff] == 16'd0) slice_ff <= '0;
         if (cmd.scan_clear) begin
            idx_ff <= '0;
            found_ff <= 1'b0;
         end
         if (cmd.scan_step) begin
            idx_ff <= idx_ff + 1'b1;
            if (rdy && (!found_ff || (ismin && keyless))) begin
               found_ff <= 1'b1;
               best_ff <= slot_i;
               bkey_ff <= key;
            end else if (rdy && !ismin) begin
               found_ff <= 1'b1;
            end
         end
         if (cmd.commit) begin
            cur_ff <= best_ff;
            if (!started_ff[best_ff]) begin
               started_ff[best_ff] <= 1'b1;
               first_ff[best_ff] <= now_ff;
            end
            if (pol == mlqs_pkg::POL_SJF) slice_ff <= rem_ff[best_ff];
            else if (pol == mlqs_pkg::POL_STCF) slice_ff <= 16'd1;
            else begin
               slice_ff <= q < rem_ff[best_ff] ? q : rem_ff[best_ff];
               rot_ff[scan_level] <= (best_ff == SW'(SLOTS - 1)) ? '0 : best_ff + 1'b1;
            end
         end
         if (cmd.run) begin
            rem_ff[cur_ff] <= rem_new;
            slice_ff <= rem_new == 16'd0 ? 16'd0 : slice_ff - 16'd1;
            now_ff <= now_new;
         end
         if (cmd.idle) now_ff <= now_new;
      end
   end

   assign rsp_data = beat_ff;
endmodule

// ===== src/multilevel_queue_cpu_scheduler.sv =====
// Four-level fixed-priority process scheduler. A load beat fills one process
// slot and answers with an all-zero beat. A tick beat either continues an
// active slice or picks a new one; picking scans every slot once per level
// examined, one slot per cycle, from the top level down until a ready
// process is found. The user must write policies and quanta only while the
// block is idle; the block itself does not enforce this.
module multilevel_queue_cpu_scheduler #(
   parameter int SLOTS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  mlqs_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output mlqs_pkg::rsp_type  rsp_data,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [7:0]         csr_wdata
);
   mlqs_pkg::cmd_type cmd;
   mlqs_pkg::sts_type sts;
   logic [1:0] scan_level;

   mlqs_ctrl #(.SLOTS(SLOTS)) u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_action(req_data.action), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .sts(sts), .cmd(cmd), .scan_level(scan_level)
   );

   mlqs_dp #(.SLOTS(SLOTS)) u_dp (
      .clock(clock), .reset(reset), .req_data(req_data), .load_beat(cmd.do_load),
      .rsp_stall(rsp_stall), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .cmd(cmd), .scan_level(scan_level), .sts(sts)
   );
endmodule

// ===== test/multilevel_queue_cpu_scheduler_tb.sv =====
module multilevel_queue_cpu_scheduler_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSLOT = 16;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   mlqs_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   mlqs_pkg::rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [2:0] csr_index = '0;
   logic [7:0] csr_wdata = '0;

   multilevel_queue_cpu_scheduler #(.SLOTS(NSLOT)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Scheduler shadow state.
   logic [1:0]  sh_policy [mlqs_pkg::LEVELS];
   logic [7:0]  sh_quantum [mlqs_pkg::LEVELS];
   logic [15:0] sh_burst [NSLOT];
   logic [15:0] sh_arrival [NSLOT];
   logic [1:0]  sh_level [NSLOT];
   logic [15:0] sh_remain [NSLOT];
   logic        sh_started [NSLOT];
   logic [15:0] sh_first [NSLOT];
   logic [15:0] sh_now;
   logic [3:0]  sh_cur;
   logic [15:0] sh_slice;
   logic [3:0]  sh_rotor [mlqs_pkg::LEVELS];

   mlqs_pkg::req_type pending_beats[$];
   mlqs_pkg::rsp_type expected_beats[$];
   int errors = 0;
   int burst_left = 0;
   int gap_left = 0;
   int stall_phase = 0;
   int sent = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic void queue_req(mlqs_pkg::req_type r);
      pending_beats.insert(pending_beats.size(), r);
   endfunction

   function automatic void queue_rsp(mlqs_pkg::rsp_type r);
      expected_beats.insert(expected_beats.size(), r);
   endfunction

   function automatic bit slot_ready(int s, int lv);
      return sh_remain[s] != 0 && sh_arrival[s] <= sh_now && sh_level[s] == lv;
   endfunction

   function automatic bit pick_slice();
      int best;
      bit found;
      int s;
      logic [15:0] key, bkey;
      logic [15:0] q;
      for (int lv = 0; lv < mlqs_pkg::LEVELS; lv++) begin
         found = 0;
         best = 0;
         if (sh_policy[lv] == mlqs_pkg::POL_SJF || sh_policy[lv] == mlqs_pkg::POL_STCF) begin
            for (s = 0; s < NSLOT; s++) begin
               if (!slot_ready(s, lv)) continue;
               if (!found) begin
                  best = s;
                  found = 1;
                  continue;
               end
               key = (sh_policy[lv] == mlqs_pkg::POL_SJF) ? sh_burst[s] : sh_remain[s];
               bkey = (sh_policy[lv] == mlqs_pkg::POL_SJF) ? sh_burst[best]
                                                            : sh_remain[best];
               if (key < bkey) best = s;
            end
         end else begin
            for (int k = 0; k < NSLOT && !found; k++) begin
               s = (sh_rotor[lv] + k) % NSLOT;
               if (slot_ready(s, lv)) begin
                  best = s;
                  found = 1;
               end
            end
         end
         if (!found) continue;
         sh_cur = 4'(best);
         if (!sh_started[best]) begin
            sh_started[best] = 1;
            sh_first[best] = sh_now;
         end
         if (sh_policy[lv] == mlqs_pkg::POL_SJF) sh_slice = sh_remain[best];
         else if (sh_policy[lv] == mlqs_pkg::POL_STCF) sh_slice = 16'd1;
         else begin
            q = (sh_quantum[lv] == 0) ? 16'd1 : 16'(sh_quantum[lv]);
            sh_slice = (q < sh_remain[best]) ? q : sh_remain[best];
            sh_rotor[lv] = 4'((best + 1) % NSLOT);
         end
         return 1;
      end
      return 0;
   endfunction

   function automatic mlqs_pkg::rsp_type schedule_beat(mlqs_pkg::req_type r);
      mlqs_pkg::rsp_type o = '0;
      int s;
      logic [15:0] tat;
      if (r.action == mlqs_pkg::ACT_LOAD) begin
         s = r.slot;
         sh_burst[s] = r.burst;
         sh_arrival[s] = r.arrival;
         sh_level[s] = r.level;
         sh_remain[s] = r.burst;
         sh_started[s] = 0;
         sh_first[s] = 0;
         if (s == sh_cur) sh_slice = 0;
         return o;
      end
      o.time_unit = sh_now;
      if (sh_slice != 0 && sh_remain[sh_cur] == 0) sh_slice = 0;
      if (sh_slice == 0 && !pick_slice()) begin
         if (sh_now != mlqs_pkg::TMAX) sh_now++;
         return o;
      end
      s = sh_cur;
      o.busy_res = 1;
      o.run_slot = 4'(s);
      sh_remain[s]--;
      sh_slice--;
      if (sh_now != mlqs_pkg::TMAX) sh_now++;
      if (sh_remain[s] == 0) begin
         sh_slice = 0;
         tat = (sh_now >= sh_arrival[s]) ? sh_now - sh_arrival[s] : 16'd0;
         o.finished = 1;
         o.completion = sh_now;
         o.turnaround = tat;
         o.waiting = (tat >= sh_burst[s]) ? tat - sh_burst[s] : 16'd0;
         o.response = sh_first[s];
      end
      return o;
   endfunction

   // Driver: bursts of beats separated by random gaps.
   always @(posedge clock) begin
      if (req_valid && !req_stall) begin
         queue_rsp(schedule_beat(req_data));
         sent++;
      end
      if (!(req_valid && req_stall)) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_beats.size() > 0 && !reset) begin
            req_data <= pending_beats.pop_front();
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(12, 1);
               gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(30, 1);
            end else burst_left <= burst_left - 1;
         end else req_valid <= 1'b0;
      end
   end

   // Monitor and receiver stall pattern.
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result beat %p", rsp_data);
         end else begin
            mlqs_pkg::rsp_type e;
            e = expected_beats.pop_front();
            if (e !== rsp_data) begin
               errors++;
               if (errors <= 10) $display("mismatch: expected %p got %p", e, rsp_data);
            end
         end
      end
      stall_phase <= (stall_phase + 1) % 64;
      rsp_stall <= (stall_phase < 24) ? ($urandom_range(2) == 0) : 1'b0;
   end

   function automatic mlqs_pkg::req_type load_beat(int s, int b, int a, int lv);
      mlqs_pkg::req_type r;
      r.action = mlqs_pkg::ACT_LOAD;
      r.slot = 4'(s);
      r.burst = 16'(b);
      r.arrival = 16'(a);
      r.level = 2'(lv);
      return r;
   endfunction

   function automatic mlqs_pkg::req_type tick_beat();
      mlqs_pkg::req_type r;
      r.action = mlqs_pkg::ACT_TICK;
      r.slot = 4'($urandom);
      r.burst = 16'($urandom);
      r.arrival = 16'($urandom);
      r.level = 2'($urandom);
      return r;
   endfunction

   task automatic write_reg(int idx, int val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= 3'(idx);
      csr_wdata <= 8'(val);
      if (idx < 4) sh_policy[idx] = 2'(val & 3);
      else sh_quantum[idx - 4] = 8'(val);
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic drain();
      while (pending_beats.size() > 0 || req_valid || expected_beats.size() > 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   initial begin
      int target;
      for (int i = 0; i < NSLOT; i++) begin
         sh_burst[i] = 0; sh_arrival[i] = 0; sh_level[i] = 0; sh_remain[i] = 0;
         sh_started[i] = 0; sh_first[i] = 0;
      end
      for (int i = 0; i < mlqs_pkg::LEVELS; i++) sh_rotor[i] = 0;
      sh_now = 0; sh_cur = 0; sh_slice = 0;
      sh_policy = '{mlqs_pkg::POL_RR, mlqs_pkg::POL_RR, mlqs_pkg::POL_RR, mlqs_pkg::POL_SJF};
      sh_quantum = '{8'd1, 8'd3, 8'd4, 8'd20};
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: idle tick, extremes, reload of the running slot, zero burst.
      queue_req(tick_beat());
      queue_req(load_beat(0, 3, 0, 0));
      queue_req(load_beat(15, 2, 0, 3));
      queue_req(load_beat(7, 0, 0, 1));
      queue_req(load_beat(5, 65535, 65535, 2));
      queue_req(load_beat(3, 2, 2, 1));
      queue_req(tick_beat());
      queue_req(load_beat(0, 2, 0, 0));
      repeat (10) queue_req(tick_beat());
      drain();

      // Random phases with different policy settings, extremes included.
      for (int ph = 0; ph < 6; ph++) begin
         for (int l = 0; l < mlqs_pkg::LEVELS; l++) begin
            write_reg(mlqs_pkg::CSR_POLICY0 + l, (ph == 5) ? 3 : $urandom_range(2));
            write_reg(mlqs_pkg::CSR_QUANTUM0 + l,
                      (ph == 0) ? 255 : (ph == 1) ? 1 : (ph == 5) ? 0 : $urandom_range(255));
         end
         target = 115;
         for (int n = 0; n < target; n++) begin
            int pick;
            pick = $urandom_range(99);
            if (pick < 30) begin
               int b;
               b = ($urandom_range(40) == 0) ? $urandom_range(65535) :
                   ($urandom_range(15) == 0) ? 0 : $urandom_range(12, 1);
               queue_req(load_beat($urandom_range(15), b,
                  ($urandom_range(20) == 0) ? $urandom_range(65535)
                                            : sh_now + sent + $urandom_range(40),
                  $urandom_range(3)));
            end else queue_req(tick_beat());
         end
         drain();
      end

      // A long process under shortest remaining on the top level to close.
      write_reg(mlqs_pkg::CSR_POLICY0, mlqs_pkg::POL_STCF);
      queue_req(load_beat(1, 65535, 0, 0));
      repeat (40) queue_req(tick_beat());
      drain();
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule

// ===== sim.f =====
src/mlqs_pkg.sv
src/mlqs_ctrl.sv
src/mlqs_dp.sv
src/multilevel_queue_cpu_scheduler.sv
test/multilevel_queue_cpu_scheduler_tb.sv
